### rtl/core/vmt_pkg.sv
// shared types, constants and helpers of the virtio mmio transport registers
`timescale 1ns / 1ps
`default_nettype none
package vmt_pkg;

    localparam int QUEUE_COUNT = 8;
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    localparam logic [31:0] MAGIC_VALUE    = 32'h7472_6976;
    localparam logic [31:0] VERSION_MODERN = 32'd2;
    localparam int          EVENT_IDX_BIT  = 29;

    localparam logic [7:0] ST_DRIVER_OK   = 8'h04;
    localparam logic [7:0] ST_FEATURES_OK = 8'h08;
    localparam logic [7:0] ST_NEEDS_RESET = 8'h40;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_IRQ   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] CFG_DEVICE_ID       = 2'd0;
    localparam logic [1:0] CFG_VENDOR_ID       = 2'd1;
    localparam logic [1:0] CFG_DEVICE_FEATURES = 2'd2;
    localparam logic [1:0] CFG_QUEUE_MAX_SIZE  = 2'd3;

    localparam logic [8:0] OFF_MAGIC       = 9'h000;
    localparam logic [8:0] OFF_VERSION     = 9'h004;
    localparam logic [8:0] OFF_DEVICE_ID   = 9'h008;
    localparam logic [8:0] OFF_VENDOR_ID   = 9'h00C;
    localparam logic [8:0] OFF_DEV_FEAT    = 9'h010;
    localparam logic [8:0] OFF_DEV_FEAT_SEL = 9'h014;
    localparam logic [8:0] OFF_DRV_FEAT    = 9'h020;
    localparam logic [8:0] OFF_DRV_FEAT_SEL = 9'h024;
    localparam logic [8:0] OFF_QUEUE_SEL   = 9'h030;
    localparam logic [8:0] OFF_QUEUE_MAX   = 9'h034;
    localparam logic [8:0] OFF_QUEUE_NUM   = 9'h038;
    localparam logic [8:0] OFF_QUEUE_READY = 9'h044;
    localparam logic [8:0] OFF_QUEUE_NOTIFY = 9'h050;
    localparam logic [8:0] OFF_INT_STATUS  = 9'h060;
    localparam logic [8:0] OFF_INT_ACK     = 9'h064;
    localparam logic [8:0] OFF_STATUS      = 9'h070;
    localparam logic [8:0] OFF_DESC_LO     = 9'h080;
    localparam logic [8:0] OFF_DESC_HI     = 9'h084;
    localparam logic [8:0] OFF_AVAIL_LO    = 9'h090;
    localparam logic [8:0] OFF_AVAIL_HI    = 9'h094;
    localparam logic [8:0] OFF_USED_LO     = 9'h0A0;
    localparam logic [8:0] OFF_USED_HI     = 9'h0A4;
    localparam logic [8:0] OFF_CFG_GEN     = 9'h0FC;

    typedef struct packed {
        logic [15:0] size;
        logic        ready;
        logic        event_index;
        logic [63:0] desc_addr;
        logic [63:0] avail_addr;
        logic [63:0] used_addr;
    } t_ring;

    localparam int RING_W = $bits(t_ring);

    function automatic logic [31:0] size_mask(input logic [3:0] size);
        logic [31:0] m;
        unique case (size)
            4'd0:    m = 32'h0000_0000;
            4'd1:    m = 32'h0000_00FF;
            4'd2:    m = 32'h0000_FFFF;
            4'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### rtl/core/vmt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/core/virtio_mmio_transport_registers.sv
// virtio mmio transport register window with per-queue state in a ram
// pipeline: an accepted item is held in stage 1, and its result then in the output register
// throughput: one item per cycle unless m_axis_tready stalls; the per-queue ram read is
//   issued at accept time and a write from the item ahead is forwarded into the one behind
// reset: synchronous active low; per-queue entries read as zero through valid bits,
//   so no clearing pass is needed, and a status write of zero clears them the same way
`timescale 1ns / 1ps
`default_nettype none
module virtio_mmio_transport_registers
    import vmt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // offset, width, write_data, zero pad
    input  wire logic [1:0]  s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data, notify_valid, notify_queue, driver_ok_pulse, device_reset_pulse,
    // interrupt_raised, interrupt_pending, zero pad
    output logic [71:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [63:0] i_cfg_wdata
);
    // configuration
    logic [15:0] r_device_id;
    logic [31:0] r_vendor_id;
    logic [63:0] r_device_features;
    logic [15:0] r_queue_max_size;

    // transport state
    logic [7:0]  r_status, n_status;
    logic [31:0] r_int_bits, n_int_bits;
    logic [31:0] r_queue_select, n_queue_select;
    logic [31:0] r_dev_sel, n_dev_sel;
    logic [31:0] r_drv_sel, n_drv_sel;
    logic [63:0] r_drv_feat, n_drv_feat;
    logic [63:0] r_st_desc, n_st_desc;
    logic [63:0] r_st_avail, n_st_avail;
    logic [63:0] r_st_used, n_st_used;
    logic [31:0] r_cfg_gen, n_cfg_gen;
    logic [QUEUE_COUNT-1:0] r_qvalid, n_qvalid;

    // stage 1
    logic          r_s1_valid;
    logic [1:0]    r_s1_kind;
    logic [8:0]    r_s1_off;
    logic [3:0]    r_s1_size;
    logic [31:0]   r_s1_data;
    logic [QW-1:0] r_s1_addr;
    logic          r_fwd_valid;
    t_ring         r_fwd_data;

    // output register
    logic          r_out_valid;
    logic [71:0]   r_out_data;

    logic          in_fire, s1_fire;
    logic [8:0]    in_off;
    logic [31:0]   in_wv;
    logic [QW-1:0] rd_addr;
    logic [RING_W-1:0] ram_rdata;
    t_ring         ent, new_ent;
    logic          ram_we;
    logic          qv;
    logic [8:0]    off_al;
    logic [31:0]   wv, rd_reg, rd_val;
    logic          nv, dok, rst_p, irq;
    logic [31:0]   nq;
    logic [7:0]    ns, adding;
    logic [71:0]   result;

    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_off = {s_axis_tdata[8:2], 2'b00};
    assign in_wv  = s_axis_tdata[44:13] & size_mask(s_axis_tdata[12:9]);

    always_comb begin
        if (s_axis_tuser == KIND_WRITE && in_off == OFF_QUEUE_SEL) begin
            rd_addr = in_wv[QW-1:0];
        end else if (s1_fire) begin
            rd_addr = n_queue_select[QW-1:0];
        end else begin
            rd_addr = r_queue_select[QW-1:0];
        end
    end

    vmt_ram #(
        .WIDTH(RING_W),
        .DEPTH(QUEUE_COUNT)
    ) u_ring_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we && s1_fire),
        .i_waddr(r_queue_select[QW-1:0]),
        .i_wdata(new_ent),
        .i_re   (in_fire),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        if (r_fwd_valid) begin
            ent = r_fwd_data;
        end else if (r_qvalid[r_s1_addr]) begin
            ent = t_ring'(ram_rdata);
        end else begin
            ent = '0;
        end
    end

    always_comb begin
        qv     = r_queue_select < 32'(QUEUE_COUNT);
        off_al = {r_s1_off[8:2], 2'b00};
        wv     = r_s1_data & size_mask(r_s1_size);

        n_status       = r_status;
        n_int_bits     = r_int_bits;
        n_queue_select = r_queue_select;
        n_dev_sel      = r_dev_sel;
        n_drv_sel      = r_drv_sel;
        n_drv_feat     = r_drv_feat;
        n_st_desc      = r_st_desc;
        n_st_avail     = r_st_avail;
        n_st_used      = r_st_used;
        n_cfg_gen      = r_cfg_gen;
        n_qvalid       = r_qvalid;
        new_ent        = ent;
        ram_we         = 1'b0;
        nv             = 1'b0;
        nq             = '0;
        dok            = 1'b0;
        rst_p          = 1'b0;
        irq            = 1'b0;
        ns             = wv[7:0];
        adding         = ns & ~r_status;

        // register read
        rd_reg = '0;
        if (!off_al[8]) begin
            unique case (off_al)
                OFF_MAGIC:       rd_reg = MAGIC_VALUE;
                OFF_VERSION:     rd_reg = VERSION_MODERN;
                OFF_DEVICE_ID:   rd_reg = {16'd0, r_device_id};
                OFF_VENDOR_ID:   rd_reg = r_vendor_id;
                OFF_DEV_FEAT:    rd_reg = (r_dev_sel == '0) ? r_device_features[31:0]
                                                            : r_device_features[63:32];
                OFF_QUEUE_MAX:   rd_reg = qv ? {16'd0, r_queue_max_size} : '0;
                OFF_QUEUE_READY: rd_reg = {31'd0, qv && ent.ready};
                OFF_INT_STATUS:  rd_reg = r_int_bits;
                OFF_STATUS:      rd_reg = {24'd0, r_status};
                OFF_CFG_GEN:     rd_reg = r_cfg_gen;
                default:         rd_reg = '0;
            endcase
        end
        rd_val = (rd_reg >> {r_s1_off[1:0], 3'b000}) & size_mask(r_s1_size);

        unique case (r_s1_kind)
            KIND_WRITE: begin
                if (off_al[8]) begin
                    n_cfg_gen = r_cfg_gen + 32'd1;
                end else begin
                    unique case (off_al)
                        OFF_DEV_FEAT_SEL: n_dev_sel = wv;
                        OFF_DRV_FEAT_SEL: n_drv_sel = wv;
                        OFF_DRV_FEAT: begin
                            if (r_drv_sel == '0) begin
                                n_drv_feat[31:0] = wv;
                            end else begin
                                n_drv_feat[63:32] = wv;
                            end
                        end
                        OFF_QUEUE_SEL: begin
                            n_queue_select = wv;
                            if (wv < 32'(QUEUE_COUNT)) begin
                                n_st_desc  = ent.desc_addr;
                                n_st_avail = ent.avail_addr;
                                n_st_used  = ent.used_addr;
                            end
                        end
                        OFF_QUEUE_NUM: begin
                            if (qv && wv <= {16'd0, r_queue_max_size}) begin
                                new_ent.size = wv[15:0];
                                ram_we       = 1'b1;
                            end
                        end
                        OFF_QUEUE_READY: begin
                            if (qv) begin
                                new_ent.desc_addr   = r_st_desc;
                                new_ent.avail_addr  = r_st_avail;
                                new_ent.used_addr   = r_st_used;
                                new_ent.event_index = r_drv_feat[EVENT_IDX_BIT];
                                new_ent.ready       = wv != '0;
                                ram_we              = 1'b1;
                            end
                        end
                        OFF_QUEUE_NOTIFY: begin
                            nv = 1'b1;
                            nq = wv;
                        end
                        OFF_INT_ACK: n_int_bits = r_int_bits & ~wv;
                        OFF_STATUS: begin
                            if (ns == '0) begin
                                rst_p          = 1'b1;
                                n_status       = '0;
                                n_int_bits     = '0;
                                n_queue_select = '0;
                                n_dev_sel      = '0;
                                n_drv_sel      = '0;
                                n_drv_feat     = '0;
                                n_st_desc      = '0;
                                n_st_avail     = '0;
                                n_st_used      = '0;
                                n_qvalid       = '0;
                            end else begin
                                if ((adding & ST_FEATURES_OK) != '0 &&
                                    (r_drv_feat & ~r_device_features) != '0) begin
                                    ns = (ns & ~ST_FEATURES_OK) | ST_NEEDS_RESET;
                                end
                                n_status = ns;
                                dok      = (adding & ST_DRIVER_OK) != '0;
                            end
                        end
                        OFF_DESC_LO:  n_st_desc[31:0]   = wv;
                        OFF_DESC_HI:  n_st_desc[63:32]  = wv;
                        OFF_AVAIL_LO: n_st_avail[31:0]  = wv;
                        OFF_AVAIL_HI: n_st_avail[63:32] = wv;
                        OFF_USED_LO:  n_st_used[31:0]   = wv;
                        OFF_USED_HI:  n_st_used[63:32]  = wv;
                        default: ;
                    endcase
                end
            end
            KIND_IRQ: begin
                n_int_bits = r_int_bits | r_s1_data;
                irq        = 1'b1;
            end
            default: ;
        endcase

        if (ram_we) begin
            n_qvalid[r_queue_select[QW-1:0]] = 1'b1;
        end

        result = {3'd0, n_int_bits != '0, irq, rst_p, dok, nq, nv,
                  (r_s1_kind == KIND_READ) ? rd_val : 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id       <= '0;
            r_vendor_id       <= '0;
            r_device_features <= 64'h0000_0001_0000_0000;
            r_queue_max_size  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEVICE_ID:       r_device_id       <= i_cfg_wdata[15:0];
                CFG_VENDOR_ID:       r_vendor_id       <= i_cfg_wdata[31:0];
                CFG_DEVICE_FEATURES: r_device_features <= i_cfg_wdata;
                CFG_QUEUE_MAX_SIZE:  r_queue_max_size  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status       <= '0;
            r_int_bits     <= '0;
            r_queue_select <= '0;
            r_dev_sel      <= '0;
            r_drv_sel      <= '0;
            r_drv_feat     <= '0;
            r_st_desc      <= '0;
            r_st_avail     <= '0;
            r_st_used      <= '0;
            r_cfg_gen      <= '0;
            r_qvalid       <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_fwd_valid    <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_status       <= n_status;
                r_int_bits     <= n_int_bits;
                r_queue_select <= n_queue_select;
                r_dev_sel      <= n_dev_sel;
                r_drv_sel      <= n_drv_sel;
                r_drv_feat     <= n_drv_feat;
                r_st_desc      <= n_st_desc;
                r_st_avail     <= n_st_avail;
                r_st_used      <= n_st_used;
                r_cfg_gen      <= n_cfg_gen;
                r_qvalid       <= n_qvalid;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= s1_fire && ram_we && rd_addr == r_queue_select[QW-1:0];
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_kind  <= s_axis_tuser;
            r_s1_off   <= s_axis_tdata[8:0];
            r_s1_size  <= s_axis_tdata[12:9];
            r_s1_data  <= s_axis_tdata[44:13];
            r_s1_addr  <= rd_addr;
            r_fwd_data <= new_ent;
        end
        if (s1_fire) begin
            r_out_data <= result;
        end
    end
endmodule
`default_nettype wire
